// ===== rtl/mir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_pkg
// Shared sizes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mir_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SW          = 32;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_W       = SW + 2;
  localparam int FRAC_BITS   = 16;
  localparam int DVD_W       = ACC_W - 1 + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_FEW = 2'd2;

  typedef struct packed {
    logic accept;
    logic ins_rd;
    logic ins_cmp;
    logic emit_start;
    logic q_rd;
    logic q_acc;
    logic e_rd;
    logic e_num;
    logic div_start;
    logic out_load;
    logic out_zero;
    logic next_i;
    logic clr_count;
  } cmd_t;

  typedef struct packed {
    logic stored;
    logic last;
    logic pos_zero;
    logic shift_more;
    logic small_set;
    logic k_last;
    logic i_last;
    logic div_done;
    logic out_valid;
  } stat_t;

endpackage

// ===== rtl/mir_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/mir_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mir_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mir_pkg::DVD_W-1:0]     dividend_i,
  input  logic [mir_pkg::ACC_W-1:0]     divisor_i,
  output logic [mir_pkg::DVD_W-1:0]     quot_o,
  output logic                          done_o
);
  import mir_pkg::*;

  logic [ACC_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     quot_q, quot_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [ACC_W:0]       shift;
  logic [ACC_W:0]       diff;

  always_comb begin
    shift  = {rem_q, quot_q[DVD_W-1]};
    diff   = shift - {1'b0, divisor_i};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = DIV_CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q && (cnt_q != '0)) begin
      if (shift >= {1'b0, divisor_i}) begin
        rem_d  = diff[ACC_W-1:0];
        quot_d = {quot_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d  = shift[ACC_W-1:0];
        quot_d = {quot_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = busy_q && (cnt_q == '0);

endmodule

// ===== rtl/mir_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_datapath
// Sample stores, insertion sort step, quartile sums, division and result.
// ----------------------------------------------------------------------------
module mir_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           sample_i,
  input  logic                  last_sample_i,
  input  mir_pkg::cmd_t         cmd_i,
  output mir_pkg::stat_t        stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           scaled_value_o,
  output logic                  last_result_o,
  output logic [1:0]            status_o
);
  import mir_pkg::*;

  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        pos_q, idx_q;
  logic [2:0]              k_q;
  logic [SW-1:0]           v_q;
  logic                    last_q, stored_q;
  logic signed [ACC_W-1:0] med2_q, lo_q, hi_q, num_q;
  logic                    out_valid_q;
  logic [31:0]             value_q;
  logic                    olast_q;
  logic [1:0]              ostat_q;

  logic                    full;
  logic                    s_we;
  logic [IDX_W-1:0]        s_waddr, s_raddr;
  logic [SW-1:0]           s_wdata, s_rdata, o_rdata;
  logic                    shift_more;
  logic [CNT_W-1:0]        half, quart, quart3, qaddr;
  logic signed [ACC_W-1:0] s_ext, o_ext, spread;
  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [DVD_W-1:0]        quot;
  logic                    div_done;
  logic                    i_last;

  assign full       = (count_q == CNT_W'(MAX_SAMPLES));
  assign shift_more = $signed(s_rdata) > $signed(v_q);
  assign s_ext      = ACC_W'($signed(s_rdata));
  assign o_ext      = ACC_W'($signed(o_rdata));
  assign spread     = hi_q - lo_q;
  assign neg        = num_q[ACC_W-1];
  assign mag        = neg ? ACC_W'(-num_q) : ACC_W'(num_q);
  assign i_last     = ({1'b0, idx_q} == (count_q - 1'b1));

  always_comb begin
    half   = count_q >> 1;
    quart  = count_q >> 2;
    quart3 = (quart << 1) + quart;
    case (k_q)
      3'd0:    qaddr = half - 1'b1;
      3'd1:    qaddr = half;
      3'd2:    qaddr = quart - 1'b1;
      3'd3:    qaddr = quart;
      3'd4:    qaddr = quart3 - 1'b1;
      default: qaddr = quart3;
    endcase
  end

  always_comb begin
    s_we    = (cmd_i.ins_rd && (pos_q == '0)) || cmd_i.ins_cmp;
    s_waddr = pos_q;
    s_wdata = (cmd_i.ins_cmp && shift_more) ? s_rdata : v_q;
    s_raddr = cmd_i.q_rd ? qaddr[IDX_W-1:0] : pos_q - 1'b1;
  end

  mir_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_orig (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && !full),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (sample_i),
    .raddr_i (idx_q),
    .rdata_o (o_rdata)
  );

  mir_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_sorted (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({mag[ACC_W-2:0], {FRAC_BITS{1'b0}}}),
    .divisor_i  (spread),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stored_q    <= 1'b0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q   <= last_sample_i;
        stored_q <= !full;
        if (!full) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end
      if (cmd_i.emit_start) begin
        idx_q <= '0;
        k_q   <= '0;
      end
      if (cmd_i.q_acc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.next_i) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.out_load || cmd_i.out_zero) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q   <= sample_i;
      pos_q <= count_q[IDX_W-1:0];
    end
    if (cmd_i.ins_cmp && shift_more) begin
      pos_q <= pos_q - 1'b1;
    end
    if (cmd_i.emit_start) begin
      med2_q <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
    end
    if (cmd_i.q_acc) begin
      if (k_q < 3'd2) begin
        med2_q <= med2_q + s_ext;
      end else if (k_q < 3'd4) begin
        lo_q <= lo_q + s_ext;
      end else begin
        hi_q <= hi_q + s_ext;
      end
    end
    if (cmd_i.e_num) begin
      num_q <= (o_ext <<< 1) - med2_q;
    end
    if (cmd_i.out_zero) begin
      value_q <= '0;
      ostat_q <= ST_FEW;
      olast_q <= i_last;
    end
    if (cmd_i.out_load) begin
      olast_q <= i_last;
      if (spread == '0) begin
        ostat_q <= ST_SAT;
        if (num_q == '0) begin
          value_q <= '0;
        end else if (neg) begin
          value_q <= 32'h8000_0000;
        end else begin
          value_q <= 32'h7fff_ffff;
        end
      end else if (neg) begin
        if (quot > DVD_W'(33'h0_8000_0000)) begin
          value_q <= 32'h8000_0000;
          ostat_q <= ST_SAT;
        end else begin
          value_q <= 32'(-quot);
          ostat_q <= ST_OK;
        end
      end else begin
        if (quot > DVD_W'(32'h7fff_ffff)) begin
          value_q <= 32'h7fff_ffff;
          ostat_q <= ST_SAT;
        end else begin
          value_q <= quot[31:0];
          ostat_q <= ST_OK;
        end
      end
    end
  end

  always_comb begin
    stat_o.stored     = stored_q;
    stat_o.last       = last_q;
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.shift_more = shift_more;
    stat_o.small_set  = (count_q < CNT_W'(4));
    stat_o.k_last     = (k_q == 3'd5);
    stat_o.i_last     = i_last;
    stat_o.div_done   = div_done;
    stat_o.out_valid  = out_valid_q;
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_value_o = value_q;
  assign last_result_o  = olast_q;
  assign status_o       = ostat_q;

endmodule

// ===== rtl/mir_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_ctrl
// Sequencer for loading, sorting, quartile gathering and result emission.
// ----------------------------------------------------------------------------
module mir_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mir_pkg::stat_t  stat_i,
  output mir_pkg::cmd_t   cmd_o
);
  import mir_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_INS_RD  = 12'b0000_0000_0010,
    S_INS_CMP = 12'b0000_0000_0100,
    S_START   = 12'b0000_0000_1000,
    S_SMALL   = 12'b0000_0001_0000,
    S_Q_RD    = 12'b0000_0010_0000,
    S_Q_ACC   = 12'b0000_0100_0000,
    S_E_RD    = 12'b0000_1000_0000,
    S_E_NUM   = 12'b0001_0000_0000,
    S_E_DIVS  = 12'b0010_0000_0000,
    S_E_DIV   = 12'b0100_0000_0000,
    S_WAIT    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_pending;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_pending = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (!stat_i.stored) begin
          state_d = stat_i.last ? S_START : S_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          if (stat_i.pos_zero) begin
            state_d = stat_i.last ? S_START : S_IDLE;
          end else begin
            state_d = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        cmd_o.ins_cmp = 1'b1;
        if (stat_i.shift_more) begin
          state_d = S_INS_RD;
        end else begin
          state_d = stat_i.last ? S_START : S_IDLE;
        end
      end
      S_START: begin
        cmd_o.emit_start = 1'b1;
        state_d          = stat_i.small_set ? S_SMALL : S_Q_RD;
      end
      S_SMALL: begin
        cmd_o.out_zero = 1'b1;
        state_d        = S_WAIT;
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd_o.q_acc = 1'b1;
        state_d     = stat_i.k_last ? S_E_RD : S_Q_RD;
      end
      S_E_RD: begin
        cmd_o.e_rd = 1'b1;
        state_d    = S_E_NUM;
      end
      S_E_NUM: begin
        cmd_o.e_num = 1'b1;
        state_d     = S_E_DIVS;
      end
      S_E_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_E_DIV;
      end
      S_E_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_WAIT;
        end
      end
      S_WAIT: begin
        out_pending = stat_i.out_valid;
        if (!out_pending) begin
          if (stat_i.i_last) begin
            cmd_o.clr_count = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.next_i = 1'b1;
            state_d      = stat_i.small_set ? S_SMALL : S_E_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/median_iqr_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_iqr_normalizer
// Robust scaling of a sample set by its median and interquartile spread.
// ----------------------------------------------------------------------------
// Each input word is stored and insertion-sorted as it arrives; for each
// larger sorted element it moves past, that element is read and then
// compared. A full set holds 64 words. A word marked last starts a pass over
// the sorted store, after which one result word follows per sample in
// arrival order; for sets of four or more, each is computed by the
// one-bit-per-cycle 49-step divider and may then wait at the output. Input is
// taken only while the block is idle.
module median_iqr_normalizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] scaled_value_o,
  output logic        last_result_o,
  output logic [1:0]  status_o
);
  import mir_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mir_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .scaled_value_o (scaled_value_o),
    .last_result_o  (last_result_o),
    .status_o       (status_o)
  );

endmodule

// ===== rtl/mir_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mir_checker
// Port-level assertions for the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] sample_i,
  input logic        last_sample_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] scaled_value_o,
  input logic        last_result_o,
  input logic [1:0]  status_o
);
  import mir_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while a result word is pending.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scaled_value_o))
    else $error("Stalled result word changed.");

  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FEW) |-> scaled_value_o == '0)
    else $error("Short-set result word is not zero.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("Undefined status code.");

endmodule

bind median_iqr_normalizer mir_checker u_mir_checker (.*);
